// ===== sv/erdt_pkg.sv =====
`default_nettype none
package erdt_pkg;

	// Seen-bit table geometry: rows of eight bits, one row per memory word.
	localparam int TableBytes = 128;
	localparam int RowW       = $clog2(TableBytes);
	localparam int BitW       = 3;
	localparam int PosW       = RowW + BitW;

	localparam int unsigned MinIcmpBytes = 8;

	localparam logic [7:0]  TypeEchoReply   = 8'd0;
	localparam logic [7:0]  TypeEchoRequest = 8'd8;
	localparam logic [7:0]  ProtoIcmp       = 8'd1;
	localparam logic [31:0] CountMax        = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		V_SENT         = 3'd0,
		V_RESPONSE     = 3'd1,
		V_DUPLICATE    = 3'd2,
		V_ERROR_FOR_US = 3'd3,
		V_IGNORED      = 3'd4,
		V_TOO_SHORT    = 3'd5
	} verdict_t;

	typedef enum logic {
		REG_OWN_IDENT    = 1'b0,
		REG_DEST_ADDRESS = 1'b1
	} reg_index_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RMW  = 1'b1
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == CountMax) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

// ===== sv/erdt_ram.sv =====
`default_nettype none
module erdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/echo_reply_duplicate_tracker.sv =====
// Echo reply duplicate tracker: bookkeeping for an ICMP echo session.
// A transaction accepted in idle has its seen-bit row read; the result is decided
// in the read-modify-write state, registered and put on the ports, marked by done.
// A new transaction is taken only in idle, not during the read-modify-write
// of one seen-bit row in the single-port-per-direction table memory.
// Reset clears counters, registers and row valid bits at once; the receiver cannot stall.
`default_nettype none
module echo_reply_duplicate_tracker
	import erdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Command channel.
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [3:0]  ip_header_words,
	input  wire logic [15:0] packet_length,
	input  wire logic [7:0]  msg_type,
	input  wire logic [15:0] msg_ident,
	input  wire logic [15:0] msg_seq,
	input  wire logic [31:0] inner_dest,
	input  wire logic [7:0]  inner_proto,
	input  wire logic [7:0]  inner_type,
	input  wire logic [15:0] inner_ident,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	// Result channel.
	output logic             done,
	output logic [2:0]       verdict,
	output logic [15:0]      sent_seq,
	output logic [31:0]      sent_count,
	output logic [31:0]      recv_count,
	output logic [31:0]      dup_count
);

	// Configuration registers. The port is always ready; the user must write only while
	// the block is idle (the block does not enforce it), so no datapath interlock is needed.
	logic [15:0] own_ident_q;
	logic [31:0] dest_address_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ident_q    <= '0;
			dest_address_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_OWN_IDENT:    own_ident_q    <= cfg_data[15:0];
				REG_DEST_ADDRESS: dest_address_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Control state machine. In idle a transaction is accepted and the row
	// holding its seen bit is read; in the read-modify-write cycle the row
	// data has arrived, the verdict is decided and the row is written back.
	state_t state_q, state_d;
	logic   accept;
	logic   rd_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		rd_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy  = 1'b0;
				rd_en = start;
				if (start) begin
					state_d = ST_RMW;
				end
			end
			ST_RMW: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = start && !busy;

	// Counters. They are the count outputs directly: they change only at the
	// end of the read-modify-write cycle, so they are stable while done is up.
	logic [31:0] send_counter_q, send_counter_d;
	logic [31:0] reply_counter_q, reply_counter_d;
	logic [31:0] dup_counter_q, dup_counter_d;

	// The table position is the sequence number modulo the table size, which
	// is a power of two, so it is simply the low bits. A send uses the send
	// count, a receive uses the received sequence number.
	logic [PosW-1:0] pos_in;

	assign pos_in = cmd ? msg_seq[PosW-1:0] : send_counter_q[PosW-1:0];

	// Captured transaction fields.
	logic            cmd_q;
	logic [3:0]      hwords_q;
	logic [15:0]     plen_q;
	logic [7:0]      mtype_q;
	logic [15:0]     mident_q;
	logic [31:0]     idest_q;
	logic [7:0]      iproto_q;
	logic [7:0]      itype_q;
	logic [15:0]     iident_q;
	logic [RowW-1:0] row_q;
	logic [BitW-1:0] bit_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			hwords_q <= ip_header_words;
			plen_q   <= packet_length;
			mtype_q  <= msg_type;
			mident_q <= msg_ident;
			idest_q  <= inner_dest;
			iproto_q <= inner_proto;
			itype_q  <= inner_type;
			iident_q <= inner_ident;
			row_q    <= pos_in[PosW-1:BitW];
			bit_q    <= pos_in[BitW-1:0];
		end
	end

	// Seen-bit table. A row that has never been written since reset has its
	// valid bit low and reads as all zero, which stands in for clearing the
	// memory after reset.
	logic [TableBytes-1:0] row_valid_q;
	logic [7:0]            rd_data;
	logic [7:0]            row_data;
	logic [7:0]            wr_data;
	logic                  wr_en;

	erdt_ram #(
		.WIDTH (8),
		.DEPTH (TableBytes)
	) u_seen_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (pos_in[PosW-1:BitW]),
		.rd_data (rd_data)
	);

	assign row_data = row_valid_q[row_q] ? rd_data : 8'd0;

	// Classification and update of the transaction in the read-modify-write
	// cycle. Only a send (clear the bit) or a new response (set the bit)
	// writes the row back; every other outcome leaves the table unchanged.
	logic        in_rmw;
	logic [16:0] min_len;
	logic        too_short;
	logic        ours;
	verdict_t    verdict_d;
	logic [15:0] seq_d;

	assign in_rmw    = (state_q == ST_RMW);
	assign min_len   = 17'({hwords_q, 2'b00}) + 17'(MinIcmpBytes);
	assign too_short = {1'b0, plen_q} < min_len;
	assign ours      = (idest_q == dest_address_q) && (iproto_q == ProtoIcmp) &&
	                   (itype_q == TypeEchoRequest) && (iident_q == own_ident_q);

	always_comb begin
		verdict_d       = V_IGNORED;
		seq_d           = 16'd0;
		wr_en           = 1'b0;
		wr_data         = row_data;
		send_counter_d  = send_counter_q;
		reply_counter_d = reply_counter_q;
		dup_counter_d   = dup_counter_q;
		if (!cmd_q) begin
			// A saturated send count keeps reusing its own table bit.
			verdict_d      = V_SENT;
			seq_d          = send_counter_q[15:0];
			wr_data[bit_q] = 1'b0;
			wr_en          = in_rmw;
			send_counter_d = sat_inc(send_counter_q);
		end else if (too_short) begin
			verdict_d = V_TOO_SHORT;
		end else if (mtype_q == TypeEchoReply) begin
			if (mident_q != own_ident_q) begin
				verdict_d = V_IGNORED;
			end else if (row_data[bit_q]) begin
				verdict_d     = V_DUPLICATE;
				dup_counter_d = sat_inc(dup_counter_q);
			end else begin
				verdict_d       = V_RESPONSE;
				wr_data[bit_q]  = 1'b1;
				wr_en           = in_rmw;
				reply_counter_d = sat_inc(reply_counter_q);
			end
		end else if (mtype_q == TypeEchoRequest) begin
			verdict_d = V_IGNORED;
		end else begin
			verdict_d = ours ? V_ERROR_FOR_US : V_IGNORED;
		end
	end

	// Counter, row valid and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_counter_q  <= '0;
			reply_counter_q <= '0;
			dup_counter_q   <= '0;
			row_valid_q     <= '0;
			done            <= 1'b0;
		end else begin
			done <= in_rmw;
			if (in_rmw) begin
				send_counter_q  <= send_counter_d;
				reply_counter_q <= reply_counter_d;
				dup_counter_q   <= dup_counter_d;
			end
			if (wr_en) begin
				row_valid_q[row_q] <= 1'b1;
			end
		end
	end

	// Result payload registers; they hold until the next transaction.
	logic [2:0]  verdict_q;
	logic [15:0] sent_seq_q;

	always_ff @(posedge clk) begin
		if (in_rmw) begin
			verdict_q  <= verdict_d;
			sent_seq_q <= seq_d;
		end
	end

	assign verdict    = verdict_q;
	assign sent_seq   = sent_seq_q;
	assign sent_count = send_counter_q;
	assign recv_count = reply_counter_q;
	assign dup_count  = dup_counter_q;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import erdt_pkg::*;

	// The seen-bit table holds one bit per sequence number modulo its size.
	localparam int unsigned TableBits = 8 * TableBytes;
	// Cycles with no transaction of any kind before the run is declared hung.
	// The longest correct quiet stretch is the reset plus a short drain.
	localparam int unsigned IdleLimit = 500;
	// Transactions that are not ignored by the block, per random phase.
	localparam int unsigned PhaseItems = 60;
	localparam int unsigned PhaseCount = 5;

	// One command transaction, laid out as the block's input ports.
	typedef struct {
		logic        cmd;
		logic [3:0]  hwords;
		logic [15:0] plen;
		logic [7:0]  mtype;
		logic [15:0] mident;
		logic [15:0] mseq;
		logic [31:0] idest;
		logic [7:0]  iproto;
		logic [7:0]  itype;
		logic [15:0] iident;
	} echo_cmd_t;

	// One result transaction, laid out as the block's output ports.
	typedef struct {
		logic [2:0]  verdict;
		logic [15:0] seq;
		logic [31:0] sends;
		logic [31:0] replies;
		logic [31:0] dups;
	} echo_res_t;

	// Keeps its own copy of the session state, classifies every accepted
	// command and holds the results that the block still owes us.
	class echo_ledger;
		logic [15:0] own_ident;
		logic [31:0] dest_address;
		bit          seen [TableBits];
		logic [31:0] sends;
		logic [31:0] replies;
		logic [31:0] dups;
		echo_res_t   awaited [$];
		bit          failed;

		function new();
			own_ident    = '0;
			dest_address = '0;
			sends        = '0;
			replies      = '0;
			dups         = '0;
			failed       = 1'b0;
			foreach (seen[i])
				seen[i] = 1'b0;
		endfunction

		function void write_reg(reg_index_t idx, logic [31:0] data);
			case (idx)
				REG_OWN_IDENT:    own_ident = data[15:0];
				REG_DEST_ADDRESS: dest_address = data;
				default: ;
			endcase
		endfunction

		function logic [2:0] record_command(echo_cmd_t c);
			echo_res_t r;
			int unsigned row;
			r.seq = '0;
			row = c.mseq % TableBits;
			if (c.cmd == 1'b0) begin
				seen[sends % TableBits] = 1'b0;
				r.seq = sends[15:0];
				if (sends != CountMax)
					sends = sends + 1;
				r.verdict = V_SENT;
			end else if (32'(c.plen) < 32'(c.hwords) * 4 + MinIcmpBytes) begin
				r.verdict = V_TOO_SHORT;
			end else if (c.mtype == TypeEchoReply) begin
				if (c.mident != own_ident) begin
					r.verdict = V_IGNORED;
				end else if (seen[row]) begin
					if (dups != CountMax)
						dups = dups + 1;
					r.verdict = V_DUPLICATE;
				end else begin
					seen[row] = 1'b1;
					if (replies != CountMax)
						replies = replies + 1;
					r.verdict = V_RESPONSE;
				end
			end else if (c.mtype == TypeEchoRequest) begin
				r.verdict = V_IGNORED;
			end else begin
				r.verdict = (c.idest == dest_address && c.iproto == ProtoIcmp &&
					c.itype == TypeEchoRequest && c.iident == own_ident) ?
					V_ERROR_FOR_US : V_IGNORED;
			end
			r.sends   = sends;
			r.replies = replies;
			r.dups    = dups;
			awaited.push_back(r);
			return r.verdict;
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			failed = 1'b1;
		endfunction

		function void check_result(echo_res_t got);
			echo_res_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual verdict %0h",
					$time, got.verdict);
				failed = 1'b1;
				return;
			end
			want = awaited.pop_front();
			if (got.verdict !== want.verdict)
				mismatch("verdict", 32'(want.verdict), 32'(got.verdict));
			if (got.seq !== want.seq)
				mismatch("sent_seq", 32'(want.seq), 32'(got.seq));
			if (got.sends !== want.sends)
				mismatch("sent_count", want.sends, got.sends);
			if (got.replies !== want.replies)
				mismatch("recv_count", want.replies, got.replies);
			if (got.dups !== want.dups)
				mismatch("dup_count", want.dups, got.dups);
		endfunction
	endclass

	// Every input starts at a known value; the block is held in reset at first.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cmd = 1'b0;
	logic [3:0]  ip_header_words = '0;
	logic [15:0] packet_length = '0;
	logic [7:0]  msg_type = '0;
	logic [15:0] msg_ident = '0;
	logic [15:0] msg_seq = '0;
	logic [31:0] inner_dest = '0;
	logic [7:0]  inner_proto = '0;
	logic [7:0]  inner_type = '0;
	logic [15:0] inner_ident = '0;
	logic        cfg_valid = 1'b0;
	reg_index_t  cfg_index = REG_OWN_IDENT;
	logic [31:0] cfg_data = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic [2:0]  verdict;
	logic [15:0] sent_seq;
	logic [31:0] sent_count;
	logic [31:0] recv_count;
	logic [31:0] dup_count;

	echo_ledger ledger = new();

	echo_reply_duplicate_tracker u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.ip_header_words (ip_header_words),
		.packet_length   (packet_length),
		.msg_type        (msg_type),
		.msg_ident       (msg_ident),
		.msg_seq         (msg_seq),
		.inner_dest      (inner_dest),
		.inner_proto     (inner_proto),
		.inner_type      (inner_type),
		.inner_ident     (inner_ident),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.verdict         (verdict),
		.sent_seq        (sent_seq),
		.sent_count      (sent_count),
		.recv_count      (recv_count),
		.dup_count       (dup_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// A send event. Its payload fields do not matter to the block, so the
	// directed part uses all zeros and all ones to toggle every bit.
	function automatic echo_cmd_t send_req(input logic fill);
		return '{1'b0, {4{fill}}, {16{fill}}, {8{fill}}, {16{fill}}, {16{fill}},
			{32{fill}}, {8{fill}}, {8{fill}}, {16{fill}}};
	endfunction

	// A received packet with the given outer header; the quoted header is random.
	function automatic echo_cmd_t pkt(input logic [3:0] hw, input logic [15:0] len,
		input logic [7:0] t, input logic [15:0] id, input logic [15:0] sq);
		return '{1'b1, hw, len, t, id, sq, 32'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom)};
	endfunction

	// Fills in the quoted original header of an ICMP error message.
	function automatic echo_cmd_t quote(input echo_cmd_t c, input logic [31:0] d,
		input logic [7:0] p, input logic [7:0] t, input logic [15:0] id);
		c.idest  = d;
		c.iproto = p;
		c.itype  = t;
		c.iident = id;
		return c;
	endfunction

	// Picks a header length of five to fifteen words and a packet length that is long enough.
	function automatic echo_cmd_t fit_length(input echo_cmd_t c);
		c.hwords = 4'($urandom_range(5, 15));
		c.plen   = 16'(4 * c.hwords + MinIcmpBytes + $urandom_range(0, 1400));
		return c;
	endfunction

	// Random traffic. Most of it is well formed against the current registers
	// so that it gets past the length and identifier filters: send events,
	// replies to recent requests (some aliasing onto the same table bit, which
	// makes duplicates), and error messages quoting our own request. The rest
	// is foreign traffic and pure noise with every field random.
	function automatic echo_cmd_t random_command();
		echo_cmd_t   c;
		int unsigned kind;
		int unsigned pick;
		logic [15:0] back;
		c = pkt(4'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			c.cmd = 1'b0;
		end else if (kind < 65) begin
			c = fit_length(c);
			c.mtype  = TypeEchoReply;
			c.mident = ledger.own_ident;
			pick = $urandom_range(0, 3);
			back = 16'($urandom_range(1, 6));
			if (pick == 0)
				c.mseq = ledger.sends[15:0] - back;
			else if (pick == 1)
				c.mseq = ledger.sends[15:0] - back + 16'(TableBits * $urandom_range(1, 63));
			else if (pick == 2)
				c.plen = 16'(4 * c.hwords + MinIcmpBytes - $urandom_range(1, 8));
		end else if (kind < 75) begin
			c = fit_length(c);
			c.mtype = (kind < 70) ? 8'($urandom_range(1, 7)) : 8'($urandom_range(9, 255));
			c = quote(c, ledger.dest_address, ProtoIcmp, TypeEchoRequest, ledger.own_ident);
			// Half of these break exactly one of the four quoted fields.
			case ($urandom_range(0, 7))
				0: c.idest = c.idest ^ 32'(1 << $urandom_range(0, 31));
				1: c.iproto = 8'($urandom_range(2, 255));
				2: c.itype = TypeEchoReply;
				3: c.iident = ~ledger.own_ident;
				default: ;
			endcase
		end else if (kind < 85) begin
			c = fit_length(c);
			if (kind < 80) begin
				c.mtype = TypeEchoRequest;
			end else begin
				c.mtype  = TypeEchoReply;
				c.mident = ledger.own_ident ^ 16'($urandom_range(1, 65535));
			end
		end
		return c;
	endfunction

	// Presents one command and holds it until the block takes it. Start is
	// left high so that the next command can follow without a bubble.
	task automatic issue_command(input echo_cmd_t c, output logic [2:0] v);
		start           <= 1'b1;
		cmd             <= c.cmd;
		ip_header_words <= c.hwords;
		packet_length   <= c.plen;
		msg_type        <= c.mtype;
		msg_ident       <= c.mident;
		msg_seq         <= c.mseq;
		inner_dest      <= c.idest;
		inner_proto     <= c.iproto;
		inner_type      <= c.itype;
		inner_ident     <= c.iident;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		v = ledger.record_command(c);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Waits until every outstanding result has come back, plus a little margin,
	// so the block is truly idle.
	task automatic drain_results();
		start <= 1'b0;
		while (ledger.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers back to back in a random order. Valid stays high
	// across the pair and drops after the second write transaction.
	task automatic program_registers(input logic [31:0] ident_word,
		input logic [31:0] dest_word);
		bit dest_first;
		dest_first = 1'($urandom_range(0, 1));
		cfg_valid <= 1'b1;
		cfg_index <= dest_first ? REG_DEST_ADDRESS : REG_OWN_IDENT;
		cfg_data  <= dest_first ? dest_word : ident_word;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		ledger.write_reg(cfg_index, cfg_data);
		cfg_index <= dest_first ? REG_OWN_IDENT : REG_DEST_ADDRESS;
		cfg_data  <= dest_first ? ident_word : dest_word;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		ledger.write_reg(cfg_index, cfg_data);
		cfg_valid <= 1'b0;
	endtask

	// Results cannot be held off, so every strobe is checked at the edge
	// that ends its cycle. An unknown strobe is checked as well.
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0)
			ledger.check_result('{verdict, sent_seq, sent_count, recv_count, dup_count});
	end

	// Ends a hung run: any accepted transaction on any channel restarts the count.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IdleLimit) begin
			@(posedge clk);
			if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		logic [2:0]  v;
		logic [15:0] ident;
		logic [31:0] dest;
		int unsigned counted;
		int unsigned burst;
		ident = 16'hA5C3;
		dest  = 32'h0A00_0001;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_registers({16'($urandom), ident}, dest);

		// Directed part. The minimum length is four bytes per header word
		// plus the eight-byte ICMP header; both sides of that boundary are
		// hit at the smallest and the largest header.
		issue_command(send_req(1'b0), v);
		issue_command(pkt(4'd5, 16'd28, TypeEchoReply, ident, 16'd0), v);
		// The same reply again is a duplicate.
		issue_command(pkt(4'd5, 16'd28, TypeEchoReply, ident, 16'd0), v);
		issue_command(pkt(4'd5, 16'd27, TypeEchoReply, ident, 16'd0), v);
		issue_command(pkt(4'd15, 16'd68, TypeEchoReply, ident, 16'd1), v);
		issue_command(pkt(4'd15, 16'd67, TypeEchoReply, ident, 16'd2), v);
		issue_command(pkt(4'd0, 16'd0, TypeEchoReply, ident, 16'd3), v);
		issue_command(pkt(4'd0, 16'd8, TypeEchoReply, ident, 16'd3), v);
		// A reply with a foreign identifier and an echo request are ignored.
		issue_command(pkt(4'd15, 16'hFFFF, TypeEchoReply, ~ident, 16'd4), v);
		issue_command(pkt(4'd5, 16'd100, TypeEchoRequest, ident, 16'd5), v);
		// Error messages: one that quotes our request, then one broken field each.
		issue_command(quote(pkt(4'd5, 16'd100, 8'd3, 16'd0, 16'd6),
			dest, ProtoIcmp, TypeEchoRequest, ident), v);
		issue_command(quote(pkt(4'd5, 16'd100, 8'd11, 16'd0, 16'd6),
			~dest, ProtoIcmp, TypeEchoRequest, ident), v);
		issue_command(quote(pkt(4'd5, 16'd100, 8'd11, 16'd0, 16'd6),
			dest, 8'd17, TypeEchoRequest, ident), v);
		issue_command(quote(pkt(4'd5, 16'd100, 8'd11, 16'd0, 16'd6),
			dest, ProtoIcmp, TypeEchoReply, ident), v);
		issue_command(quote(pkt(4'd5, 16'd100, 8'd11, 16'd0, 16'd6),
			dest, ProtoIcmp, TypeEchoRequest, ~ident), v);
		issue_command(quote(pkt(4'd15, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF),
			dest, ProtoIcmp, TypeEchoRequest, ident), v);
		// Sending with count one clears the bit that an early reply had set,
		// so the next reply to it is new again; its alias one table length up
		// then hits the same bit and counts as a duplicate.
		issue_command(send_req(1'b0), v);
		issue_command(pkt(4'd5, 16'd28, TypeEchoReply, ident, 16'd1), v);
		issue_command(pkt(4'd5, 16'd28, TypeEchoReply, ident, 16'(TableBits + 1)), v);
		issue_command(pkt(4'd5, 16'd28, TypeEchoReply, ident, 16'hFFFF), v);
		issue_command(send_req(1'b1), v);
		drain_results();

		// Random phases, each under its own register setting: first the all
		// ones and all zeros extremes, then random values. The counters cannot
		// reach their ceiling in a run of this length.
		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0: begin
					ident = 16'hFFFF;
					dest  = 32'hFFFF_FFFF;
				end
				1: begin
					ident = 16'h0000;
					dest  = 32'h0000_0000;
				end
				default: begin
					ident = 16'($urandom);
					dest  = $urandom;
				end
			endcase
			program_registers({16'($urandom), ident}, dest);

			// The sender works in bursts of random length with random gaps.
			// The block takes no new command while it is busy with the last one, so the
			// gaps land on both phases of its work.
			counted = 0;
			burst = $urandom_range(1, 24);
			while (counted < PhaseItems) begin
				if (burst == 0) begin
					pause_sender($urandom_range(1, 6));
					burst = $urandom_range(1, 24);
				end
				issue_command(random_command(), v);
				if (v != V_IGNORED)
					counted++;
				burst--;
			end
			drain_results();
		end

		if (ledger.failed)
			$display("== FAIL ==");
		else
			$display("== PASS ==");
		$finish;
	end

endmodule
